[src/calm_pkg.sv]
// Shared types and constants of the CIDR allow list match block.
// Used by the top level; has no dependencies of its own.
`default_nettype none
package calm_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int MAX_RULES   = 256;

    localparam int SLOT_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int IDX_W    = $clog2(MAX_RULES);
    localparam int ADDR_W   = SLOT_W + IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int RULE_W   = 65;

    typedef enum logic [2:0] {
        OP_LOOKUP       = 3'd0,
        OP_WRITE_RULE   = 3'd1,
        OP_REMOVE_RULE  = 3'd2,
        OP_WRITE_COUNT  = 3'd3,
        OP_REMOVE_COUNT = 3'd4,
        OP_ENABLE       = 3'd5,
        OP_DISABLE      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        R_NO_POLICY  = 3'd0,
        R_NO_COUNT   = 3'd1,
        R_MATCHED    = 3'd2,
        R_MISSING    = 3'd3,
        R_PAST_COUNT = 3'd4,
        R_EXHAUSTED  = 3'd5,
        R_UPDATE     = 3'd6
    } t_reason;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_SCAN  = 3'b100
    } t_state;

endpackage
`default_nettype wire

[src/calm_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module calm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

[src/cidr_allow_list_match_top.sv]
// Top level of the CIDR allow list match block.
// Depends on calm_pkg and calm_ram.
`default_nettype none
// Usage:
// A word is offered on the i_ fields with start high; it is taken at a rising
// edge where start is high and busy is low. Every word gives one result word,
// shown on o_verdict, o_reason and o_decided_index for one cycle with o_valid
// high. The receiver cannot stall, so results are never held back.
// Update words (flags, count, rule writes and removals) finish at once: the
// result appears in the cycle after acceptance and busy stays low, so updates
// may be issued in every cycle.
// A lookup that is decided by the slot flags answers in the next cycle too.
// Otherwise it scans the rule entries of its slot from the rule RAM, one entry
// per cycle through the single RAM port, and busy stays high until the result
// is shown; the scan starts at entry 1 and stops at entry MAX_RULES - 1 at
// the latest, 255 at the default setting.
// After reset the block clears the valid bits of all 2 ** (SLOT_W + IDX_W) rule
// RAM entries, 4096 at the default setting, in one pass with busy high.
module cidr_allow_list_match_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [3:0]  i_source_slot,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [7:0]  i_rule_index,
    input  wire logic [31:0] i_rule_address,
    input  wire logic [31:0] i_rule_mask,
    input  wire logic [7:0]  i_count_value,
    output logic             o_valid,
    output logic             o_verdict,
    output logic [2:0]       o_reason,
    output logic [7:0]       o_decided_index
);
    import calm_pkg::*;

    t_state r_state, n_state;
    logic   r_policy    [NUM_SOURCES];
    logic   r_cnt_valid [NUM_SOURCES];
    logic [7:0] r_count [NUM_SOURCES];

    logic [ADDR_W-1:0] r_clr;
    logic [SLOT_W-1:0] r_slot;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [31:0]       r_dest;
    logic [7:0]        r_lim;

    logic        r_valid, n_valid;
    logic        r_verdict, n_verdict;
    t_reason     r_reason, n_reason;
    logic [7:0]  r_index, n_index;

    logic              accept;
    t_op               op;
    logic              slot_ok;
    logic              idx_ok;
    logic [SLOT_W-1:0] slot_i;
    logic [IDX_W-1:0]  ridx_i;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [RULE_W-1:0] ram_wdata;
    logic [RULE_W-1:0] ram_rdata;
    logic              ent_valid;
    logic [31:0]       ent_addr;
    logic [31:0]       ent_mask;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign op       = t_op'(i_op);
    assign slot_ok  = (32'(i_source_slot) < NUM_SOURCES);
    assign idx_ok   = (i_rule_index != 8'd0) && (32'(i_rule_index) < MAX_RULES);
    assign slot_i   = SLOT_W'(i_source_slot);
    assign ridx_i   = IDX_W'(i_rule_index);

    assign ent_valid = ram_rdata[64];
    assign ent_addr  = ram_rdata[63:32];
    assign ent_mask  = ram_rdata[31:0];

    calm_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RAM_DEPTH)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = {r_slot, r_idx + IDX_W'(1)};
        ram_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            ST_IDLE: begin
                if (op == OP_LOOKUP) begin
                    ram_addr = {slot_i, IDX_W'(1)};
                end else begin
                    ram_addr = {slot_i, ridx_i};
                end
                if (accept && slot_ok && idx_ok && op == OP_WRITE_RULE) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, i_rule_address, i_rule_mask};
                end else if (accept && slot_ok && idx_ok && op == OP_REMOVE_RULE) begin
                    ram_we = 1'b1;
                end
            end
            ST_SCAN: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_verdict = 1'b0;
        n_reason  = R_UPDATE;
        n_index   = 8'd0;
        unique case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr) == RAM_DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    if (op == OP_LOOKUP) begin
                        if (!slot_ok || !r_policy[slot_i]) begin
                            n_reason = R_NO_POLICY;
                        end else if (!r_cnt_valid[slot_i]) begin
                            n_reason = R_NO_COUNT;
                        end else begin
                            n_valid = 1'b0;
                            n_idx   = IDX_W'(1);
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (32'(r_idx) > 32'(r_lim)) begin
                    n_valid   = 1'b1;
                    n_verdict = 1'b1;
                    n_reason  = R_PAST_COUNT;
                    n_index   = 8'(r_idx);
                    n_state   = ST_IDLE;
                end else if (!ent_valid) begin
                    n_valid  = 1'b1;
                    n_reason = R_MISSING;
                    n_index  = 8'(r_idx);
                    n_state  = ST_IDLE;
                end else if ((ent_addr & ent_mask) == (r_dest & ent_mask)) begin
                    n_valid  = 1'b1;
                    n_reason = R_MATCHED;
                    n_index  = 8'(r_idx);
                    n_state  = ST_IDLE;
                end else if (32'(r_idx) == MAX_RULES - 1) begin
                    n_valid   = 1'b1;
                    n_verdict = 1'b1;
                    n_reason  = R_EXHAUSTED;
                    n_state   = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_policy[s]    <= 1'b0;
                r_cnt_valid[s] <= 1'b0;
                r_count[s]     <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (accept && slot_ok) begin
                case (op)
                    OP_WRITE_COUNT: begin
                        r_cnt_valid[slot_i] <= 1'b1;
                        r_count[slot_i]     <= i_count_value;
                    end
                    OP_REMOVE_COUNT: r_cnt_valid[slot_i] <= 1'b0;
                    OP_ENABLE:       r_policy[slot_i]    <= 1'b1;
                    OP_DISABLE:      r_policy[slot_i]    <= 1'b0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_verdict <= n_verdict;
        r_reason  <= n_reason;
        r_index   <= n_index;
        if (accept) begin
            r_slot <= slot_i;
            r_dest <= i_dest_address;
            r_lim  <= r_count[slot_i];
        end
    end

    assign o_valid         = r_valid;
    assign o_verdict       = r_verdict;
    assign o_reason        = r_reason;
    assign o_decided_index = r_index;

`ifndef SYNTH
    a_quiet_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid)
        else $error("result shown during the clearing pass");

    a_lookup_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_LOOKUP) |=> (o_valid || busy))
        else $error("accepted lookup neither answered nor in progress");

    a_block_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict) |-> (o_reason == R_PAST_COUNT || o_reason == R_EXHAUSTED))
        else $error("block verdict with an allowing reason");

    a_exhausted_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reason == R_EXHAUSTED) |-> (o_decided_index == 8'd0))
        else $error("exhausted table reported with a non-zero index");

    a_scan_ends_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && n_state == ST_IDLE) |=> o_valid)
        else $error("scan ended without a result");
`endif

endmodule
`default_nettype wire

[tb/cidr_allow_list_match_top_tb.sv]
// Self-checking testbench of the CIDR allow list match block: a directed table, a full
// rule table for one slot, then random policy, count, rule and lookup words.
// Depends on calm_pkg and the top level; a local model or fixed rows give expected verdicts.
`timescale 1ns / 100ps

module cidr_allow_list_match_top_tb;

    import calm_pkg::*;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         QUIET_LIMIT = 20000;
    localparam int         N_RANDOM    = 760;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [31:0] dest;
        logic [7:0]  ridx;
        logic [31:0] raddr;
        logic [31:0] rmask;
        logic [7:0]  cval;
    } t_word;

    typedef struct packed {
        logic       verdict;
        t_reason    reason;
        logic [7:0] idx;
    } t_result;

    typedef struct {
        t_word   w;
        bit      fixed;
        t_result r;
    } t_probe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_op = '0;
    logic [3:0]  i_source_slot = '0;
    logic [31:0] i_dest_address = '0;
    logic [7:0]  i_rule_index = '0;
    logic [31:0] i_rule_address = '0;
    logic [31:0] i_rule_mask = '0;
    logic [7:0]  i_count_value = '0;
    logic        o_valid;
    logic        o_verdict;
    logic [2:0]  o_reason;
    logic [7:0]  o_decided_index;

    bit          policy_on [NUM_SOURCES];
    bit          count_on [NUM_SOURCES];
    bit   [7:0]  count_val [NUM_SOURCES];
    bit          rule_on [RAM_DEPTH];
    bit   [31:0] rule_addr [RAM_DEPTH];
    bit   [31:0] rule_mask [RAM_DEPTH];

    t_result     verdicts_due [$];
    t_probe      probe_rows [$];
    int          faults = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;

    cidr_allow_list_match_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_source_slot   (i_source_slot),
        .i_dest_address  (i_dest_address),
        .i_rule_index    (i_rule_index),
        .i_rule_address  (i_rule_address),
        .i_rule_mask     (i_rule_mask),
        .i_count_value   (i_count_value),
        .o_valid         (o_valid),
        .o_verdict       (o_verdict),
        .o_reason        (o_reason),
        .o_decided_index (o_decided_index)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result judge_word(t_word w);
        int  base;
        int  e;
        bit  idx_ok;
        base   = int'(w.slot) * MAX_RULES;
        idx_ok = (w.ridx >= 1) && (int'(w.ridx) < MAX_RULES);
        if (w.op == OP_LOOKUP) begin
            if (int'(w.slot) >= NUM_SOURCES || !policy_on[w.slot]) begin
                return '{1'b0, R_NO_POLICY, 8'd0};
            end
            if (!count_on[w.slot]) begin
                return '{1'b0, R_NO_COUNT, 8'd0};
            end
            for (int i = 1; i < MAX_RULES; i++) begin
                e = base + i;
                if (i > int'(count_val[w.slot])) begin
                    return '{1'b1, R_PAST_COUNT, 8'(i)};
                end
                if (!rule_on[e]) begin
                    return '{1'b0, R_MISSING, 8'(i)};
                end
                if ((rule_addr[e] & rule_mask[e]) == (w.dest & rule_mask[e])) begin
                    return '{1'b0, R_MATCHED, 8'(i)};
                end
            end
            return '{1'b1, R_EXHAUSTED, 8'd0};
        end
        if (int'(w.slot) < NUM_SOURCES) begin
            case (w.op)
                OP_WRITE_RULE: begin
                    if (idx_ok) begin
                        rule_on[base + w.ridx]   = 1'b1;
                        rule_addr[base + w.ridx] = w.raddr;
                        rule_mask[base + w.ridx] = w.rmask;
                    end
                end
                OP_REMOVE_RULE: begin
                    if (idx_ok) begin
                        rule_on[base + w.ridx] = 1'b0;
                    end
                end
                OP_WRITE_COUNT: begin
                    count_on[w.slot]  = 1'b1;
                    count_val[w.slot] = w.cval;
                end
                OP_REMOVE_COUNT: count_on[w.slot] = 1'b0;
                OP_ENABLE:       policy_on[w.slot] = 1'b1;
                OP_DISABLE:      policy_on[w.slot] = 1'b0;
                default: ;
            endcase
        end
        return '{1'b0, R_UPDATE, 8'd0};
    endfunction

    function automatic void add_probe(logic [2:0] op, int slot, logic [31:0] dest, int ridx,
                                      logic [31:0] raddr, logic [31:0] rmask, int cval,
                                      bit fixed = 1'b0, logic v = 1'b0,
                                      t_reason r = R_UPDATE, int idx = 0);
        t_probe p;
        p.w     = '{op, 4'(slot), dest, 8'(ridx), raddr, rmask, 8'(cval)};
        p.fixed = fixed;
        p.r     = '{v, r, 8'(idx)};
        probe_rows.push_back(p);
    endfunction

    function automatic t_word random_word();
        t_word w;
        int    pick;
        int    len;
        int    e;
        w    = '{3'($urandom), 4'($urandom), $urandom, 8'($urandom), $urandom, $urandom,
                 8'($urandom)};
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) begin
            w.slot = 4'($urandom_range(0, 3));
        end
        if (pick < 38) begin
            w.op = OP_LOOKUP;
            e    = int'(w.slot) * MAX_RULES + $urandom_range(1, 12);
            if ($urandom_range(0, 9) < 6 && rule_on[e]) begin
                w.dest = (rule_addr[e] & rule_mask[e]) | (w.dest & ~rule_mask[e]);
            end
        end else if (pick < 70) begin
            w.op = (pick < 63) ? OP_WRITE_RULE : OP_REMOVE_RULE;
            if ($urandom_range(0, 9) != 0) begin
                w.ridx = 8'($urandom_range(1, 12));
            end
            len = $urandom_range(0, 32);
            if ($urandom_range(0, 4) != 0) begin
                w.rmask = (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
            end
        end else if (pick < 80) begin
            w.op = OP_WRITE_COUNT;
            if ($urandom_range(0, 6) != 0) begin
                w.cval = 8'($urandom_range(0, 12));
            end
        end else if (pick < 84) begin
            w.op = OP_REMOVE_COUNT;
        end else if (pick < 92) begin
            w.op = OP_ENABLE;
        end else if (pick < 96) begin
            w.op = OP_DISABLE;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input t_word w, input bit fixed = 1'b0,
                             input t_result typed = '0);
        t_result got;
        @(negedge i_clk);
        start          <= 1'b1;
        i_op           <= w.op;
        i_source_slot  <= w.slot;
        i_dest_address <= w.dest;
        i_rule_index   <= w.ridx;
        i_rule_address <= w.raddr;
        i_rule_mask    <= w.rmask;
        i_count_value  <= w.cval;
        do @(posedge i_clk); while (busy !== 1'b0);
        got = judge_word(w);
        verdicts_due.push_back(fixed ? typed : got);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_valid === 1'b1) begin
            if (verdicts_due.size() == 0) begin
                $error("result word arrived with no word expected");
                faults++;
            end else begin
                due = verdicts_due.pop_front();
                if (o_verdict !== due.verdict) begin
                    $error("verdict: expected %0d, got %0d", due.verdict, o_verdict);
                    faults++;
                end
                if (o_reason !== due.reason) begin
                    $error("reason: expected %0d, got %0d", due.reason, o_reason);
                    faults++;
                end
                if (o_decided_index !== due.idx) begin
                    $error("decided_index: expected %0d, got %0d", due.idx,
                           o_decided_index);
                    faults++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_word w;
        add_probe(OP_LOOKUP, 15, 32'hFFFF_FFFF, 0, 32'h0, 32'h0, 0, 1, 0, R_NO_POLICY, 0);
        add_probe(OP_UNUSED, 0, 32'hFFFF_FFFF, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255,
                  1, 0, R_UPDATE, 0);
        add_probe(OP_WRITE_RULE, 0, 32'h0, 2, 32'h0A00_0000, 32'hFF00_0000, 0);
        add_probe(OP_ENABLE, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_UPDATE, 0);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_NO_COUNT, 0);
        add_probe(OP_WRITE_COUNT, 0, 32'h0, 0, 32'h0, 32'h0, 0);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 1, R_PAST_COUNT, 1);
        add_probe(OP_WRITE_COUNT, 0, 32'h0, 0, 32'h0, 32'h0, 3);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_MISSING, 1);
        add_probe(OP_WRITE_RULE, 0, 32'h0, 1, 32'hC0A8_0000, 32'hFFFF_0000, 0);
        add_probe(OP_WRITE_RULE, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_UPDATE, 0);
        add_probe(OP_LOOKUP, 0, 32'hC0A8_1234, 0, 32'h0, 32'h0, 0, 1, 0, R_MATCHED, 1);
        add_probe(OP_LOOKUP, 0, 32'h0AFF_FFFF, 0, 32'h0, 32'h0, 0);
        add_probe(OP_LOOKUP, 0, 32'hFFFF_FFFF, 0, 32'h0, 32'h0, 0, 1, 0, R_MISSING, 3);
        add_probe(OP_WRITE_RULE, 0, 32'h0, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 1, R_PAST_COUNT, 4);
        add_probe(OP_LOOKUP, 0, 32'hFFFF_FFFF, 0, 32'h0, 32'h0, 0);
        add_probe(OP_REMOVE_RULE, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_UPDATE, 0);
        add_probe(OP_REMOVE_RULE, 0, 32'h0, 1, 32'h0, 32'h0, 0);
        add_probe(OP_LOOKUP, 0, 32'hC0A8_1234, 0, 32'h0, 32'h0, 0);
        add_probe(OP_WRITE_RULE, 0, 32'h0, 1, 32'h0, 32'h0, 0);
        add_probe(OP_WRITE_COUNT, 0, 32'h0, 0, 32'h0, 32'h0, 255);
        add_probe(OP_LOOKUP, 0, 32'h1234_5678, 0, 32'h0, 32'h0, 0);
        add_probe(OP_REMOVE_COUNT, 0, 32'h0, 0, 32'h0, 32'h0, 0);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_NO_COUNT, 0);
        add_probe(OP_DISABLE, 0, 32'h0, 0, 32'h0, 32'h0, 0);
        add_probe(OP_LOOKUP, 0, 32'h0, 0, 32'h0, 32'h0, 0, 1, 0, R_NO_POLICY, 0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[n]) begin
            pace();
            send_word(probe_rows[n].w, probe_rows[n].fixed, probe_rows[n].r);
        end
        drain();

        // Slot 15 gets a full table that no destination with bit 0 clear can match.
        w = '{OP_ENABLE, 4'd15, 32'h0, 8'd0, 32'h0, 32'h0, 8'd255};
        send_word(w);
        w.op = OP_WRITE_COUNT;
        send_word(w);
        for (int k = 1; k < MAX_RULES; k++) begin
            w = '{OP_WRITE_RULE, 4'd15, $urandom, 8'(k), $urandom | 32'h1, 32'hFFFF_FFFF,
                  8'($urandom)};
            send_word(w);
        end
        w = '{OP_LOOKUP, 4'd15, $urandom & ~32'h1, 8'd0, 32'h0, 32'h0, 8'd0};
        send_word(w);
        w.op   = OP_WRITE_COUNT;
        w.cval = 8'd254;
        send_word(w);
        w.op = OP_LOOKUP;
        send_word(w);
        w.op   = OP_REMOVE_RULE;
        w.ridx = 8'd255;
        send_word(w);
        w.op   = OP_WRITE_COUNT;
        w.cval = 8'd255;
        send_word(w);
        w.op = OP_LOOKUP;
        send_word(w);
        w.dest = rule_addr[15 * MAX_RULES + 200];
        send_word(w);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            pace();
            if (n % 250 == 249) begin
                drain();
            end
            send_word(random_word());
        end
        drain();
        repeat (300) @(posedge i_clk);

        if (faults == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
src/calm_pkg.sv
src/calm_ram.sv
src/cidr_allow_list_match_top.sv
tb/cidr_allow_list_match_top_tb.sv
